### rtl/core/lcdnw_pkg.sv
// Shared types and constants for the character LCD nibble write sequencer.
// No dependencies; imported by every module of the core.
`default_nettype none

package lcdnw_pkg;

  localparam int unsigned TimerBits    = 16;
  localparam int unsigned PulseBits    = 16;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

  localparam logic [PulseBits-1:0] PulseTicksRst = PulseBits'(40);
  localparam logic [7:0] CmdClassMask = 8'hE0;
  localparam logic [7:0] FuncSetCode  = 8'h20;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SEND = 1'b1
  } op_e;

  typedef enum logic {
    REG_PULSE_TICKS = 1'b0,
    REG_REPEAT_FS   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e        op;
    logic       is_data;
    logic [7:0] value;
    logic       busy;
  } item_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } queue_stat_t;

endpackage

`default_nettype wire

### rtl/core/lcdnw_front.sv
// Input side: takes stream words, decodes them into queue items.
// Depends on lcdnw_pkg.
`default_nettype none

module lcdnw_front import lcdnw_pkg::*; (
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire queue_stat_t q_stat_i,
  output logic             push_o,
  output item_t            item_o
);

  assign s_axis_tready = !q_stat_i.full;
  assign push_o        = s_axis_tvalid && !q_stat_i.full;

  always_comb begin
    item_o         = '0;
    item_o.op      = s_axis_tuser[0] ? OP_SEND : OP_TICK;
    item_o.is_data = s_axis_tuser[1];
    item_o.value   = s_axis_tdata[7:0];
    item_o.busy    = s_axis_tdata[8];
    if (s_axis_tdata[15:9] != '0) begin
      item_o.value = s_axis_tdata[7:0];
    end
  end

endmodule

`default_nettype wire

### rtl/core/lcdnw_queue.sv
// Short item queue between the decode side and the sequencer.
// Depends on lcdnw_pkg.
`default_nettype none

module lcdnw_queue import lcdnw_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output item_t      head_o,
  output queue_stat_t stat_o
);

  item_t mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrBits:0]   count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == (QueuePtrBits+1)'(QueueDepth));
  assign stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

### rtl/core/lcdnw_back.sv
// Sequencer: phase machine, tick timer, config registers and result register.
// Depends on lcdnw_pkg.
`default_nettype none

module lcdnw_back import lcdnw_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire queue_stat_t          q_stat_i,
  input  wire item_t                head_i,
  output logic                      pop_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic                 cfg_index_i,
  input  wire logic [PulseBits-1:0] cfg_data_i,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [15:0]               m_axis_tdata
);

  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhHiSet  = 4'd1;
  localparam logic [3:0] PhHiPul  = 4'd2;
  localparam logic [3:0] PhHi2Set = 4'd3;
  localparam logic [3:0] PhHi2Pul = 4'd4;
  localparam logic [3:0] PhLoSet  = 4'd5;
  localparam logic [3:0] PhLoPul  = 4'd6;
  localparam logic [3:0] PhRdSet  = 4'd7;
  localparam logic [3:0] PhRdPul  = 4'd8;

  // largest count the timer holds
  localparam logic [32:0] TimerCap = (33'd1 << TimerBits) - 33'd1;

  logic [PulseBits-1:0] pulse_ticks_q;
  logic                 repeat_fs_q;
  logic [3:0]           phase_q, phase_d, phase_adv;
  logic [TimerBits-1:0] tick_q, tick_d, tick_inc, span_lim;
  logic [32:0]          pulse_ext;
  logic [7:0]           byte_q, byte_d;
  logic                 is_data_q, is_data_d;
  logic                 out_valid_q;
  logic [15:0]          out_q, out_d;
  logic                 take, acc, func_set;
  logic                 rs, rw, en, drv;
  logic [3:0]           nib;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ticks_q <= PulseTicksRst;
      repeat_fs_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PULSE_TICKS: pulse_ticks_q <= cfg_data_i;
        REG_REPEAT_FS:   repeat_fs_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign take  = !q_stat_i.empty && (!out_valid_q || m_axis_tready);
  assign pop_o = take;

  assign pulse_ext = 33'(pulse_ticks_q);
  assign span_lim  = (pulse_ticks_q == '0) ? TimerBits'(1) :
                     (pulse_ext > TimerCap) ? TimerCap[TimerBits-1:0] :
                     pulse_ext[TimerBits-1:0];
  assign tick_inc = tick_q + 1'b1;
  assign func_set = !is_data_q && ((byte_q & CmdClassMask) == FuncSetCode);

  always_comb begin
    case (phase_q)
      PhHiSet:  phase_adv = PhHiPul;
      PhHiPul:  phase_adv = (repeat_fs_q && func_set) ? PhHi2Set : PhLoSet;
      PhHi2Set: phase_adv = PhHi2Pul;
      PhHi2Pul: phase_adv = PhLoSet;
      PhLoSet:  phase_adv = PhLoPul;
      PhLoPul:  phase_adv = PhRdSet;
      PhRdSet:  phase_adv = PhRdPul;
      PhRdPul:  phase_adv = head_i.busy ? PhRdSet : PhIdle;
      default:  phase_adv = PhIdle;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    byte_d    = byte_q;
    is_data_d = is_data_q;
    acc       = 1'b0;
    if (head_i.op == OP_SEND) begin
      if (phase_q == PhIdle) begin
        byte_d    = head_i.value;
        is_data_d = head_i.is_data;
        tick_d    = '0;
        phase_d   = PhHiSet;
        acc       = 1'b1;
      end
    end else if (phase_q != PhIdle) begin
      tick_d = tick_inc;
      if (tick_inc >= span_lim) begin
        tick_d  = '0;
        phase_d = phase_adv;
      end
    end
  end

  always_comb begin
    rs  = 1'b0;
    rw  = 1'b1;
    en  = 1'b0;
    nib = '0;
    drv = 1'b0;
    case (phase_d)
      PhHiSet, PhHiPul, PhHi2Set, PhHi2Pul: begin
        rs  = is_data_d;
        rw  = 1'b0;
        drv = 1'b1;
        nib = byte_d[7:4];
        en  = (phase_d == PhHiPul) || (phase_d == PhHi2Pul);
      end
      PhLoSet, PhLoPul: begin
        rs  = is_data_d;
        rw  = 1'b0;
        drv = 1'b1;
        nib = byte_d[3:0];
        en  = (phase_d == PhLoPul);
      end
      PhRdPul: en = 1'b1;
      default: ;
    endcase
    out_d = {6'b0, acc, (phase_d == PhIdle), drv, nib, en, rw, rs};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      tick_q      <= '0;
      byte_q      <= '0;
      is_data_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q   <= phase_d;
        tick_q    <= tick_d;
        byte_q    <= byte_d;
        is_data_q <= is_data_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef NO_ASSERTIONS
  a_idle_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> tick_q == '0)
    else $error("timer not cleared while idle");

  a_timer_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhIdle |-> tick_q < span_lim)
    else $error("timer past span limit");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && acc |=> phase_q == PhHiSet && m_axis_tdata[8] == 1'b0)
    else $error("accepted send did not start a sequence");

  a_bus_released_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[7] |-> m_axis_tdata[1] && m_axis_tdata[6:3] == '0)
    else $error("bus released without read mode");
`endif

endmodule

`default_nettype wire

### rtl/core/char_lcd_nibble_write_sequencer_core.sv
// Top level of the character LCD 4-bit write sequencer.
// Instantiates lcdnw_front, lcdnw_queue and lcdnw_back; depends on lcdnw_pkg.
//
// Usage:
//  Input stream: one word per tick or send request. tuser[0] selects send (1) or
//  tick (0), tuser[1] marks a data byte; tdata carries the byte and the sampled
//  busy pin. A send is taken only while idle; every word yields one result word.
//  Output stream: line levels after the word (rs, rw, enable, nibble, drive),
//  the idle flag and whether a send was taken.
//  Config channel: index 0 pulse_ticks, index 1 repeat_function_set; always ready,
//  to be written by the user between sequences; the block does not enforce this.
//  An accepted word is stored in the queue, then its result is held in the result register.
//  Throughput: one word per cycle while the result output is not stalled.
//  A 4-entry queue decouples decode from the sequencer; when the result is
//  stalled the queue fills and tready drops once it holds four words.
//  Reset: phase idle, timer and held byte cleared, registers at defaults
//  (40 ticks, repeat on), no result pending.
`default_nettype none

module char_lcd_nibble_write_sequencer_core import lcdnw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] value, [8] busy_in
  input  wire logic [1:0]  s_axis_tuser,  // [0] func, [1] is_data
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] rs_out, [1] rw_out, [2] enable_out, [6:3] nibble_out, [7] drive_out,
  // [8] ready_res, [9] accepted
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  queue_stat_t q_stat;
  item_t       push_item, head_item;
  logic        push, pop;

  lcdnw_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .item_o        (push_item)
  );

  lcdnw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .head_o (head_item),
    .stat_o (q_stat)
  );

  lcdnw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .head_i        (head_item),
    .pop_o         (pop),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### test/char_lcd_nibble_write_sequencer_core_test.sv
// Self-checking testbench for char_lcd_nibble_write_sequencer_core: random tick/send
// words stream in, every result word is checked against a per-word sequencer
// predictor. Depends on lcdnw_pkg and the core RTL.
`default_nettype none

module char_lcd_nibble_write_sequencer_core_test;
  import lcdnw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 1000;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_HI_SET,
    SEQ_HI_PULSE,
    SEQ_HI2_SET,
    SEQ_HI2_PULSE,
    SEQ_LO_SET,
    SEQ_LO_PULSE,
    SEQ_RD_SET,
    SEQ_RD_PULSE
  } seq_phase_e;

  typedef struct {
    seq_phase_e      phase;
    logic [15:0]     ticks;
    logic [7:0]      held_byte;
    logic            held_is_data;
  } lcd_seq_t;

  typedef struct {
    logic [15:0] pulse_ticks;
    logic        fs_twice;
  } lcd_cfg_t;

  // result word, lowest bit last
  typedef struct packed {
    logic [5:0] pad;
    logic       accepted;
    logic       ready;
    logic       drive;
    logic [3:0] nibble;
    logic       enable;
    logic       rw;
    logic       rs;
  } lcd_lines_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  item_t      pending_q[$];
  lcd_lines_t line_q[$];
  lcd_seq_t   gen_seq;
  lcd_seq_t   chk_seq;
  lcd_cfg_t   gen_cfg;
  lcd_cfg_t   chk_cfg;
  int         gen_words;
  int         errors;
  int         stall_cycles;
  int         src_gap;
  int         sink_gap;
  bit         in_took;
  bit         calm;

  char_lcd_nibble_write_sequencer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic lcd_lines_t lcd_step(inout lcd_seq_t st, input lcd_cfg_t c,
                                          input item_t it);
    lcd_lines_t  o;
    logic [15:0] lim;
    logic        fs;
    lim = (c.pulse_ticks == 16'd0) ? 16'd1 : c.pulse_ticks;
    o = '0;
    o.rw = 1'b1;
    if (it.op == OP_SEND) begin
      if (st.phase == SEQ_IDLE) begin
        st.held_byte = it.value;
        st.held_is_data = it.is_data;
        st.ticks = '0;
        st.phase = SEQ_HI_SET;
        o.accepted = 1'b1;
      end
    end else if (st.phase != SEQ_IDLE) begin
      st.ticks = st.ticks + 16'd1;
      if (st.ticks >= lim) begin
        st.ticks = '0;
        fs = c.fs_twice && !st.held_is_data &&
             ((st.held_byte & CmdClassMask) == FuncSetCode);
        case (st.phase)
          SEQ_HI_SET:    st.phase = SEQ_HI_PULSE;
          SEQ_HI_PULSE:  st.phase = fs ? SEQ_HI2_SET : SEQ_LO_SET;
          SEQ_HI2_SET:   st.phase = SEQ_HI2_PULSE;
          SEQ_HI2_PULSE: st.phase = SEQ_LO_SET;
          SEQ_LO_SET:    st.phase = SEQ_LO_PULSE;
          SEQ_LO_PULSE:  st.phase = SEQ_RD_SET;
          SEQ_RD_SET:    st.phase = SEQ_RD_PULSE;
          SEQ_RD_PULSE:  st.phase = it.busy ? SEQ_RD_SET : SEQ_IDLE;
          default:       st.phase = SEQ_IDLE;
        endcase
      end
    end
    case (st.phase)
      SEQ_HI_SET, SEQ_HI_PULSE, SEQ_HI2_SET, SEQ_HI2_PULSE: begin
        o.rs = st.held_is_data;
        o.rw = 1'b0;
        o.drive = 1'b1;
        o.nibble = st.held_byte[7:4];
        o.enable = (st.phase == SEQ_HI_PULSE) || (st.phase == SEQ_HI2_PULSE);
      end
      SEQ_LO_SET, SEQ_LO_PULSE: begin
        o.rs = st.held_is_data;
        o.rw = 1'b0;
        o.drive = 1'b1;
        o.nibble = st.held_byte[3:0];
        o.enable = (st.phase == SEQ_LO_PULSE);
      end
      SEQ_RD_PULSE: o.enable = 1'b1;
      default: ;
    endcase
    o.ready = (st.phase == SEQ_IDLE);
    return o;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // word source
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_took) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(0, 4);
          s_axis_tvalid <= 1'b0;
        end else begin : drive_word
          item_t it;
          it = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'd0, it.busy, it.value};
          s_axis_tuser <= {it.is_data, it.op};
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      sink_gap <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin : monitor
    item_t      it;
    lcd_lines_t got;
    lcd_lines_t want;
    in_took <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.op = op_e'(s_axis_tuser[0]);
        it.is_data = s_axis_tuser[1];
        it.value = s_axis_tdata[7:0];
        it.busy = s_axis_tdata[8];
        line_q.push_back(lcd_step(chk_seq, chk_cfg, it));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = lcd_lines_t'(m_axis_tdata);
        if (line_q.size() == 0) begin
          $error("unexpected result word %0h", m_axis_tdata);
          errors++;
        end else begin
          want = line_q.pop_front();
          check_field("rs_out", 16'(want.rs), 16'(got.rs));
          check_field("rw_out", 16'(want.rw), 16'(got.rw));
          check_field("enable_out", 16'(want.enable), 16'(got.enable));
          check_field("nibble_out", 16'(want.nibble), 16'(got.nibble));
          check_field("drive_out", 16'(want.drive), 16'(got.drive));
          check_field("ready_res", 16'(want.ready), 16'(got.ready));
          check_field("accepted", 16'(want.accepted), 16'(got.accepted));
          check_field("pad", 16'(want.pad), 16'(got.pad));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic push_word(op_e op, logic d, logic [7:0] v, logic b);
    item_t it;
    it.op = op;
    it.is_data = d;
    it.value = v;
    it.busy = b;
    void'(lcd_step(gen_seq, gen_cfg, it));
    pending_q.push_back(it);
    gen_words++;
  endtask

  task automatic push_tick(logic b);
    push_word(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), b);
  endtask

  // ticks and occasional sends until idle again; busy_pct sets how often busy reads 1
  task automatic run_seq(int busy_pct);
    while (gen_seq.phase != SEQ_IDLE) begin
      if ($urandom_range(0, 11) == 0)
        push_word(OP_SEND, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      else
        push_tick($urandom_range(0, 99) < busy_pct);
    end
  endtask

  task automatic random_words(int n);
    int         start;
    logic [7:0] v;
    logic       d;
    start = gen_words;
    while (gen_words - start < n) begin
      repeat ($urandom_range(0, 2)) push_tick(1'($urandom_range(0, 1)));
      v = 8'($urandom_range(0, 255));
      d = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
        v[7:5] = 3'b001;
        d = 1'b0;
      end
      push_word(OP_SEND, d, v, 1'($urandom_range(0, 1)));
      run_seq(50);
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_PULSE_TICKS) begin
      chk_cfg.pulse_ticks = data;
      gen_cfg.pulse_ticks = data;
    end else begin
      chk_cfg.fs_twice = data[0];
      gen_cfg.fs_twice = data[0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || s_axis_tvalid || line_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    gen_seq = '{SEQ_IDLE, 16'd0, 8'd0, 1'b0};
    chk_seq = gen_seq;
    gen_cfg = '{PulseTicksRst, 1'b1};
    chk_cfg = gen_cfg;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: function set at 40 ticks per span
    push_word(OP_SEND, 1'b0, 8'h28, 1'b0);
    run_seq(0);
    wait_drained();

    // zero pulse length acts as one tick; idle ticks, ignored send, busy reread
    write_reg(REG_PULSE_TICKS, 16'd0);
    write_reg(REG_REPEAT_FS, 16'd1);
    push_word(OP_TICK, 1'b1, 8'hFF, 1'b1);
    push_word(OP_TICK, 1'b0, 8'h00, 1'b0);
    push_word(OP_SEND, 1'b0, 8'h28, 1'b0);
    push_word(OP_SEND, 1'b1, 8'hFF, 1'b1);
    repeat (8) push_word(OP_TICK, 1'b0, 8'h00, 1'b1);
    run_seq(0);
    push_word(OP_SEND, 1'b1, 8'h3F, 1'b0);
    run_seq(0);
    wait_drained();

    // function set without repeat, byte extremes
    write_reg(REG_PULSE_TICKS, 16'd1);
    write_reg(REG_REPEAT_FS, 16'd0);
    push_word(OP_SEND, 1'b0, 8'h20, 1'b0);
    run_seq(0);
    push_word(OP_SEND, 1'b0, 8'h00, 1'b1);
    run_seq(30);
    push_word(OP_SEND, 1'b1, 8'hFF, 1'b0);
    run_seq(30);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin : rand_phase
      logic [15:0] widths [6];
      widths = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd7};
      calm = (ph == 5) || ($urandom_range(0, 3) == 0);
      write_reg(REG_PULSE_TICKS, widths[$urandom_range(0, 5)]);
      write_reg(REG_REPEAT_FS, 16'($urandom_range(0, 1)));
      random_words(90);
      wait_drained();
    end

    // widest pulse: only the start of a sequence fits in the run
    write_reg(REG_PULSE_TICKS, 16'hFFFF);
    write_reg(REG_REPEAT_FS, 16'd1);
    push_word(OP_SEND, 1'b0, 8'h2A, 1'b0);
    repeat (200) push_tick(1'($urandom_range(0, 1)));

    while (pending_q.size() != 0 || s_axis_tvalid || line_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && line_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/core/lcdnw_pkg.sv
rtl/core/lcdnw_front.sv
rtl/core/lcdnw_queue.sv
rtl/core/lcdnw_back.sv
rtl/core/char_lcd_nibble_write_sequencer_core.sv
test/char_lcd_nibble_write_sequencer_core_test.sv
